@@ sv/atl_pkg.sv @@
package atl_pkg;

  localparam int FIELD_BITS = 16;
  localparam int KIND_BITS  = 4;

  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [KIND_BITS-1:0]  kind_t;

  localparam kind_t KIND_END      = 4'd0;
  localparam kind_t KIND_NEWLINE  = 4'd1;
  localparam kind_t KIND_LBRACKET = 4'd2;
  localparam kind_t KIND_RBRACKET = 4'd3;
  localparam kind_t KIND_COMMA    = 4'd4;
  localparam kind_t KIND_COLON    = 4'd5;
  localparam kind_t KIND_IDENT    = 4'd6;
  localparam kind_t KIND_REGISTER = 4'd7;
  localparam kind_t KIND_NUMBER   = 4'd8;
  localparam kind_t KIND_ERROR    = 4'd9;

  typedef struct packed {
    kind_t  kind;
    field_t line;
    field_t start;
    field_t length;
  } token_t;

  // One queue entry holds every token that a single input item produces.
  typedef struct packed {
    token_t first;
    token_t second;
    logic   pair;
  } entry_t;

endpackage

@@ sv/atl_front.sv @@
module atl_front #(
  parameter int POSITION_BITS = 16,
  parameter int LINE_BITS     = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [7:0]       char_byte,
  input  logic             end_of_input,
  input  logic             push,
  input  logic             full,
  output logic             q_wr,
  output atl_pkg::entry_t  q_data
);

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_COMMENT = 5'b00010,
    MODE_IDENT   = 5'b00100,
    MODE_NUMBER  = 5'b01000,
    MODE_ERROR   = 5'b10000
  } mode_t;

  localparam logic [7:0] CH_HASH       = 8'h23;
  localparam logic [7:0] CH_R          = 8'h72;
  localparam logic [7:0] CH_MINUS      = 8'h2d;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_NEWLINE    = 8'h0a;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_TAB        = 8'h09;
  localparam logic [7:0] CH_CR         = 8'h0d;
  localparam logic [7:0] CH_LBRACKET   = 8'h5b;
  localparam logic [7:0] CH_RBRACKET   = 8'h5d;
  localparam logic [7:0] CH_COMMA      = 8'h2c;
  localparam logic [7:0] CH_COLON      = 8'h3a;

  mode_t                    mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] start_r, start_nxt;
  logic [POSITION_BITS-1:0] len_r, len_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [LINE_BITS-1:0]     line_r, line_nxt;
  logic                     regc_r, regc_nxt;

  logic                     accept;
  logic                     is_digit, is_alpha, is_sep, is_punct;
  logic [POSITION_BITS-1:0] len_inc, pos_inc;
  logic [LINE_BITS-1:0]     line_inc;
  logic                     pending;
  logic                     handled;
  logic                     flush_v, single_v;
  atl_pkg::token_t          flush_tok, single_tok;
  atl_pkg::kind_t           punct_kind;

  assign accept   = push & ~full;
  assign is_digit = char_byte inside {[8'h30:8'h39]};
  assign is_alpha = char_byte inside {[8'h61:8'h7a], [8'h41:8'h5a]};
  assign is_sep   = char_byte inside {CH_SPACE, CH_TAB, CH_CR};
  assign is_punct = char_byte inside {CH_LBRACKET, CH_RBRACKET, CH_COMMA, CH_COLON};

  assign len_inc  = (len_r == '1) ? len_r : len_r + 1'b1;
  assign pos_inc  = (pos_r == '1) ? pos_r : pos_r + 1'b1;
  assign line_inc = (line_r == '1) ? line_r : line_r + 1'b1;

  assign pending = (mode_r == MODE_IDENT) || (mode_r == MODE_NUMBER);

  always_comb begin
    case (char_byte)
      CH_LBRACKET: punct_kind = atl_pkg::KIND_LBRACKET;
      CH_RBRACKET: punct_kind = atl_pkg::KIND_RBRACKET;
      CH_COMMA:    punct_kind = atl_pkg::KIND_COMMA;
      default:     punct_kind = atl_pkg::KIND_COLON;
    endcase
  end

  // The pending identifier or number, as it would be emitted on a flush.
  always_comb begin
    if (mode_r == MODE_NUMBER) begin
      flush_tok.kind = atl_pkg::KIND_NUMBER;
    end else if (regc_r && (len_r > POSITION_BITS'(1))) begin
      flush_tok.kind = atl_pkg::KIND_REGISTER;
    end else begin
      flush_tok.kind = atl_pkg::KIND_IDENT;
    end
    flush_tok.line   = atl_pkg::field_t'(line_r);
    flush_tok.start  = atl_pkg::field_t'(start_r);
    flush_tok.length = atl_pkg::field_t'(len_r);
  end

  always_comb begin
    mode_nxt  = mode_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    line_nxt  = line_r;
    regc_nxt  = regc_r;
    handled   = 1'b0;
    flush_v   = 1'b0;
    single_v  = 1'b0;
    single_tok.kind   = atl_pkg::KIND_END;
    single_tok.line   = atl_pkg::field_t'(line_r);
    single_tok.start  = atl_pkg::field_t'(pos_r);
    single_tok.length = atl_pkg::field_t'(1);
    if (accept) begin
      if (end_of_input) begin
        flush_v  = pending;
        single_v = 1'b1;
        single_tok.length = '0;
        mode_nxt  = MODE_IDLE;
        start_nxt = '0;
        len_nxt   = '0;
        pos_nxt   = '0;
        line_nxt  = LINE_BITS'(1);
        regc_nxt  = 1'b0;
      end else if (mode_r != MODE_ERROR) begin
        case (mode_r)
          MODE_COMMENT: begin
            handled = (char_byte != CH_NEWLINE);
          end
          MODE_IDENT: begin
            if (is_alpha || is_digit || char_byte == CH_UNDERSCORE) begin
              handled  = 1'b1;
              regc_nxt = regc_r & is_digit;
              len_nxt  = len_inc;
            end
          end
          MODE_NUMBER: begin
            if (is_digit) begin
              handled = 1'b1;
              len_nxt = len_inc;
            end
          end
          default: ;
        endcase
        if (!handled) begin
          flush_v  = pending;
          mode_nxt = MODE_IDLE;
          len_nxt  = '0;
          regc_nxt = 1'b0;
          if (is_sep) begin
            mode_nxt = MODE_IDLE;
          end else if (char_byte == CH_HASH) begin
            mode_nxt = MODE_COMMENT;
          end else if (char_byte == CH_NEWLINE) begin
            single_v        = 1'b1;
            single_tok.kind = atl_pkg::KIND_NEWLINE;
            line_nxt        = line_inc;
          end else if (is_punct) begin
            single_v        = 1'b1;
            single_tok.kind = punct_kind;
          end else if (is_alpha || char_byte == CH_UNDERSCORE) begin
            mode_nxt  = MODE_IDENT;
            start_nxt = pos_r;
            len_nxt   = POSITION_BITS'(1);
            regc_nxt  = (char_byte == CH_R);
          end else if (is_digit || char_byte == CH_MINUS) begin
            mode_nxt  = MODE_NUMBER;
            start_nxt = pos_r;
            len_nxt   = POSITION_BITS'(1);
          end else begin
            single_v        = 1'b1;
            single_tok.kind = atl_pkg::KIND_ERROR;
            mode_nxt        = MODE_ERROR;
          end
        end
        pos_nxt = pos_inc;
      end
    end
  end

  assign q_wr          = flush_v | single_v;
  assign q_data.first  = flush_v ? flush_tok : single_tok;
  assign q_data.second = single_tok;
  assign q_data.pair   = flush_v & single_v;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
      len_r   <= '0;
      pos_r   <= '0;
      line_r  <= LINE_BITS'(1);
      regc_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      line_r  <= line_nxt;
      regc_r  <= regc_nxt;
    end
  end

endmodule

@@ sv/atl_queue.sv @@
module atl_queue #(
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  atl_pkg::entry_t  wr_data,
  output logic             full,
  input  logic             rd_en,
  output atl_pkg::entry_t  rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  atl_pkg::entry_t slots_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_wr, do_rd;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

@@ sv/atl_back.sv @@
module atl_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_empty,
  input  atl_pkg::entry_t        q_data,
  output logic                   q_rd,
  output atl_pkg::kind_t         token_kind,
  output atl_pkg::field_t        token_line,
  output atl_pkg::field_t        token_start,
  output atl_pkg::field_t        token_length,
  output logic                   last_of_item,
  output logic                   empty,
  input  logic                   pop
);

  logic            valid_r, valid_nxt;
  logic            half_r, half_nxt;
  atl_pkg::token_t tok_r, tok_nxt;
  logic            last_r, last_nxt;
  logic            load;
  logic            first_only;

  assign load       = ~q_empty & (~valid_r | pop);
  // A paired entry stays at the queue head until its second token is out.
  assign first_only = q_data.pair & ~half_r;
  assign q_rd       = load & ~first_only;

  always_comb begin
    valid_nxt = valid_r;
    half_nxt  = half_r;
    tok_nxt   = tok_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = 1'b1;
      half_nxt  = first_only;
      tok_nxt   = half_r ? q_data.second : q_data.first;
      last_nxt  = ~first_only;
    end else if (pop) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      half_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      half_r  <= half_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    last_r <= last_nxt;
  end

  assign empty        = ~valid_r;
  assign token_kind   = tok_r.kind;
  assign token_line   = tok_r.line;
  assign token_start  = tok_r.start;
  assign token_length = tok_r.length;
  assign last_of_item = last_r;

endmodule

@@ sv/assembly_token_lexer.sv @@
// Streaming lexer for assembly source text. Bytes enter on the in_ channel,
// which behaves like the write side of a queue: an item (one byte, or an
// end-of-input mark) is taken on a clock edge where in_push is high and
// in_full is low. Token descriptors leave on the out_ channel, the read side
// of a queue: while out_empty is low the oldest token is on the out_ ports,
// and out_pop takes it. out_last_of_item marks the final token of each item.
// Throughput is one byte per cycle on the input while in_full is low, and
// one token per cycle on the output while out_pop stays high; an item that
// closes a pending token and makes a token of its own yields two tokens.
// The classifier updates the lexer state in the cycle the byte is taken and
// writes its tokens into a QUEUE_DEPTH-entry queue; the output register loads
// from the queue head, so a token reaches the out_ ports through a queue slot
// and then the output register, the second token of a pair after the first.
// When the receiver stalls, tokens collect in the queue and in_full rises
// once the queue fills. Synchronous reset empties the queue and the output
// register and sets the line count to one and the byte offset to zero.
module assembly_token_lexer #(
  parameter int POSITION_BITS = 16,
  parameter int LINE_BITS     = 16,
  parameter int QUEUE_DEPTH   = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_char_byte,
  input  logic        in_end_of_input,
  input  logic        in_push,
  output logic        in_full,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_token_line,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_last_of_item,
  output logic        out_empty,
  input  logic        out_pop
);

  logic            q_wr, q_rd, q_full, q_empty;
  atl_pkg::entry_t q_wr_data, q_rd_data;

  assign in_full = q_full;

  atl_front #(
    .POSITION_BITS(POSITION_BITS),
    .LINE_BITS    (LINE_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .char_byte   (in_char_byte),
    .end_of_input(in_end_of_input),
    .push        (in_push),
    .full        (q_full),
    .q_wr        (q_wr),
    .q_data      (q_wr_data)
  );

  atl_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (q_wr),
    .wr_data(q_wr_data),
    .full   (q_full),
    .rd_en  (q_rd),
    .rd_data(q_rd_data),
    .empty  (q_empty)
  );

  atl_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (q_empty),
    .q_data      (q_rd_data),
    .q_rd        (q_rd),
    .token_kind  (out_token_kind),
    .token_line  (out_token_line),
    .token_start (out_token_start),
    .token_length(out_token_length),
    .last_of_item(out_last_of_item),
    .empty       (out_empty),
    .pop         (out_pop)
  );

endmodule
